// File: rtl/gds_pkg.sv
// ----------------------------------------------------------------------------
// gds_pkg: shared types, constants and calendar functions
// Date record, function codes, controller states and the Gregorian
// leap-year and month-length helpers used by the clamp and step logic.
// ----------------------------------------------------------------------------
package gds_pkg;

  localparam int unsigned DAY_IN_W   = 6;
  localparam int unsigned DAY_W      = 5;
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned YEAR_W     = 14;
  localparam int unsigned COUNT_IN_W = 16;
  localparam int unsigned DIFF_W     = 22;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned MAX_YEAR_DEF   = 9999;

  localparam logic [YEAR_W-1:0]  MIN_YEAR  = 14'd1900;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_ADD  = 2'd1,
    FUNC_SUB  = 2'd2,
    FUNC_CMP  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CMP_LESS    = 2'd0,
    CMP_EQUAL   = 2'd1,
    CMP_GREATER = 2'd2
  } cmp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_STEP,
    ST_DIFF,
    ST_PUSH
  } state_t;

  // Field order makes a plain packed compare a chronological compare.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // (h * 128) mod 400 for the upper seven bits of a year.
  typedef logic [127:0][8:0] r400_tbl_t;

  function automatic r400_tbl_t build_r400_tbl();
    r400_tbl_t   t;
    int unsigned acc;
    acc = 0;
    for (int i = 0; i < 128; i++) begin
      t[i] = acc[8:0];
      acc  = acc + 128;
      if (acc >= 400) begin
        acc = acc - 400;
      end
    end
    return t;
  endfunction

  localparam r400_tbl_t R400_TBL = build_r400_tbl();

  // The year mod 400 comes from the table plus the low seven bits, with
  // one conditional subtract. Century years are those whose remainder is
  // a multiple of 100.
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [9:0] r;
    r = {1'b0, R400_TBL[y[13:7]]} + {3'b000, y[6:0]};
    if (r >= 10'd400) begin
      r = r - 10'd400;
    end
    return (y[1:0] == 2'b00) &&
           ((r == 10'd0) || ((r != 10'd100) && (r != 10'd200) && (r != 10'd300)));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic [YEAR_W-1:0]  y);
    logic [DAY_W-1:0] len;
    case (m) inside
      MONTH_FEB:                  len = is_leap(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
      default:                    len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/gds_if.sv
// ----------------------------------------------------------------------------
// gds_if: valid/ready channels of the date stepper
// One interface for the command channel and one for the result channel.
// ----------------------------------------------------------------------------
interface gds_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        func;
  logic [gds_pkg::DAY_IN_W-1:0]      in_day;
  logic [gds_pkg::MONTH_W-1:0]       in_month;
  logic [gds_pkg::YEAR_W-1:0]        in_year;
  logic [gds_pkg::COUNT_IN_W-1:0]    day_count;

  modport source (output valid, func, in_day, in_month, in_year, day_count,
                  input ready);
  modport sink   (input valid, func, in_day, in_month, in_year, day_count,
                  output ready);
endinterface

interface gds_out_if;
  logic                              valid;
  logic                              ready;
  logic [gds_pkg::DAY_W-1:0]         out_day;
  logic [gds_pkg::MONTH_W-1:0]       out_month;
  logic [gds_pkg::YEAR_W-1:0]        out_year;
  logic                              input_valid;
  logic [1:0]                        compare_result;
  logic [gds_pkg::DIFF_W-1:0]        day_difference;
  logic                              limit_hit;

  modport source (output valid, out_day, out_month, out_year, input_valid,
                  compare_result, day_difference, limit_hit,
                  input ready);
  modport sink   (input valid, out_day, out_month, out_year, input_valid,
                  compare_result, day_difference, limit_hit,
                  output ready);
endinterface

// File: rtl/gds_clamp.sv
// ----------------------------------------------------------------------------
// gds_clamp: raw date to legal date
// Forces year, month and day into range and flags whether anything changed.
// ----------------------------------------------------------------------------
module gds_clamp #(
  parameter int unsigned MAX_YEAR = gds_pkg::MAX_YEAR_DEF
) (
  input  logic [gds_pkg::DAY_IN_W-1:0] raw_day,
  input  logic [gds_pkg::MONTH_W-1:0]  raw_month,
  input  logic [gds_pkg::YEAR_W-1:0]   raw_year,
  output gds_pkg::date_t               date,
  output logic                         ok
);

  localparam logic [gds_pkg::YEAR_W-1:0] MAX_Y = gds_pkg::YEAR_W'(MAX_YEAR);

  logic [gds_pkg::DAY_W-1:0] len;

  always_comb begin
    ok = 1'b1;

    date.year = raw_year;
    if (raw_year < gds_pkg::MIN_YEAR) begin
      date.year = gds_pkg::MIN_YEAR;
      ok        = 1'b0;
    end else if (raw_year > MAX_Y) begin
      date.year = MAX_Y;
      ok        = 1'b0;
    end

    date.month = raw_month;
    if ((raw_month < gds_pkg::MONTH_JAN) || (raw_month > gds_pkg::MONTH_DEC)) begin
      date.month = gds_pkg::MONTH_JAN;
      ok         = 1'b0;
    end

    len      = gds_pkg::month_len(date.month, date.year);
    date.day = raw_day[gds_pkg::DAY_W-1:0];
    if ((raw_day == 6'd0) || (raw_day > 6'd31)) begin
      date.day = 5'd1;
      ok       = 1'b0;
    end else if (raw_day[gds_pkg::DAY_W-1:0] > len) begin
      date.day = len;
      ok       = 1'b0;
    end
  end

endmodule

// File: rtl/gds_day_step.sv
// ----------------------------------------------------------------------------
// gds_day_step: one-day increment / decrement unit
// Moves a legal date one day forward or backward with month and year wrap.
// ----------------------------------------------------------------------------
module gds_day_step (
  input  gds_pkg::date_t cur,
  input  logic           dec,
  output gds_pkg::date_t nxt
);

  logic [gds_pkg::MONTH_W-1:0] prev_month;
  logic [gds_pkg::DAY_W-1:0]   len_cur;
  logic [gds_pkg::DAY_W-1:0]   len_prev;

  assign prev_month = cur.month - 4'd1;
  assign len_cur    = gds_pkg::month_len(cur.month, cur.year);
  assign len_prev   = gds_pkg::month_len(prev_month, cur.year);

  always_comb begin
    nxt = cur;
    if (!dec) begin
      if (cur.day == len_cur) begin
        nxt.day = 5'd1;
        if (cur.month == gds_pkg::MONTH_DEC) begin
          nxt.month = gds_pkg::MONTH_JAN;
          nxt.year  = cur.year + 14'd1;
        end else begin
          nxt.month = cur.month + 4'd1;
        end
      end else begin
        nxt.day = cur.day + 5'd1;
      end
    end else begin
      if (cur.day == 5'd1) begin
        if (cur.month == gds_pkg::MONTH_JAN) begin
          nxt.month = gds_pkg::MONTH_DEC;
          nxt.day   = 5'd31;
          nxt.year  = cur.year - 14'd1;
        end else begin
          nxt.month = prev_month;
          nxt.day   = len_prev;
        end
      end else begin
        nxt.day = cur.day - 5'd1;
      end
    end
  end

endmodule

// File: rtl/gregorian_date_stepper.sv
// ----------------------------------------------------------------------------
// gregorian_date_stepper: Gregorian calendar day counter
// Holds one date and loads, steps, or measures it against another date.
// ----------------------------------------------------------------------------
// The block takes one command transaction at a time and answers each with
// exactly one result transaction. A load stores the clamped date and goes
// straight to the push state, which writes the result register once that
// register is free. Adding or subtracting N days walks the stored date
// through the single-day step unit once per cycle, and the walk stops early
// at 1 Jan 1900 or 31 Dec MAX_YEAR. A compare walks the earlier date forward
// through the same step unit until it meets the later one, counting the
// days between the two dates. The command channel is ready only while the
// controller is idle; a finished result sits in the output register until
// the sink takes it, and the next command can be accepted meanwhile.
// ----------------------------------------------------------------------------
module gregorian_date_stepper #(
  parameter int unsigned COUNT_BITS = gds_pkg::COUNT_BITS_DEF,
  parameter int unsigned MAX_YEAR   = gds_pkg::MAX_YEAR_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  gds_in_if.sink        in_if,
  gds_out_if.source     out_if
);

  localparam logic [gds_pkg::YEAR_W-1:0] MAX_Y = gds_pkg::YEAR_W'(MAX_YEAR);

  // End points of the calendar range.
  localparam gds_pkg::date_t DATE_HI = '{year:  MAX_Y,
                                          month: gds_pkg::MONTH_DEC,
                                          day:   5'd31};
  localparam gds_pkg::date_t DATE_LO = '{year:  gds_pkg::MIN_YEAR,
                                          month: gds_pkg::MONTH_JAN,
                                          day:   5'd1};

  gds_pkg::state_t state_r, state_nxt;

  // Stored date and working registers.
  gds_pkg::date_t          cur_r,   cur_nxt;
  gds_pkg::date_t          work_r,  work_nxt;
  gds_pkg::date_t          tgt_r,   tgt_nxt;
  gds_pkg::date_t          in_r,    in_nxt;
  gds_pkg::func_t          func_r,  func_nxt;
  logic                    ok_r,    ok_nxt;
  logic                    limit_r, limit_nxt;
  gds_pkg::cmp_t           cmp_r,   cmp_nxt;
  logic [COUNT_BITS-1:0]   steps_r, steps_nxt;
  logic [gds_pkg::DIFF_W-1:0] diff_r, diff_nxt;

  // Result register.
  logic                       out_valid_r, out_valid_nxt;
  gds_pkg::date_t             out_date_r,  out_date_nxt;
  logic                       out_ok_r,    out_ok_nxt;
  gds_pkg::cmp_t              out_cmp_r,   out_cmp_nxt;
  logic [gds_pkg::DIFF_W-1:0] out_diff_r,  out_diff_nxt;
  logic                       out_limit_r, out_limit_nxt;

  gds_pkg::date_t clamp_date;
  logic           clamp_ok;
  gds_pkg::date_t step_date;
  logic           step_dec;
  logic           in_fire;
  logic           push_ok;
  logic           at_limit;
  logic [COUNT_BITS+gds_pkg::COUNT_IN_W-1:0] count_ext;

  gds_clamp #(
    .MAX_YEAR (MAX_YEAR)
  ) u_clamp (
    .raw_day   (in_if.in_day),
    .raw_month (in_if.in_month),
    .raw_year  (in_if.in_year),
    .date      (clamp_date),
    .ok        (clamp_ok)
  );

  // The shared step unit always works on the working date. Only a
  // subtract walks backward; compares walk the earlier date forward.
  assign step_dec = (func_r == gds_pkg::FUNC_SUB);

  gds_day_step u_step (
    .cur (work_r),
    .dec (step_dec),
    .nxt (step_date)
  );

  assign in_if.ready = (state_r == gds_pkg::ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign push_ok     = !out_valid_r || out_if.ready;
  assign count_ext   = {{COUNT_BITS{1'b0}}, in_if.day_count};
  assign at_limit    = step_dec ? (work_r == DATE_LO) : (work_r == DATE_HI);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gds_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (gds_pkg::func_t'(in_if.func))
            gds_pkg::FUNC_LOAD: state_nxt = gds_pkg::ST_PUSH;
            gds_pkg::FUNC_ADD,
            gds_pkg::FUNC_SUB:  state_nxt = gds_pkg::ST_STEP;
            gds_pkg::FUNC_CMP:  state_nxt = gds_pkg::ST_CMP;
            default:            state_nxt = gds_pkg::ST_PUSH;
          endcase
        end
      end
      gds_pkg::ST_CMP:  state_nxt = gds_pkg::ST_DIFF;
      gds_pkg::ST_STEP: begin
        if ((steps_r == '0) || at_limit) begin
          state_nxt = gds_pkg::ST_PUSH;
        end
      end
      gds_pkg::ST_DIFF: begin
        if (work_r == tgt_r) begin
          state_nxt = gds_pkg::ST_PUSH;
        end
      end
      gds_pkg::ST_PUSH: begin
        if (push_ok) begin
          state_nxt = gds_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gds_pkg::ST_IDLE;
    endcase
  end

  // Datapath and result updates.
  always_comb begin
    cur_nxt       = cur_r;
    work_nxt      = work_r;
    tgt_nxt       = tgt_r;
    in_nxt        = in_r;
    func_nxt      = func_r;
    ok_nxt        = ok_r;
    limit_nxt     = limit_r;
    cmp_nxt       = cmp_r;
    steps_nxt     = steps_r;
    diff_nxt      = diff_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_date_nxt  = out_date_r;
    out_ok_nxt    = out_ok_r;
    out_cmp_nxt   = out_cmp_r;
    out_diff_nxt  = out_diff_r;
    out_limit_nxt = out_limit_r;

    unique case (state_r)
      gds_pkg::ST_IDLE: begin
        if (in_fire) begin
          func_nxt  = gds_pkg::func_t'(in_if.func);
          in_nxt    = clamp_date;
          ok_nxt    = clamp_ok;
          limit_nxt = 1'b0;
          work_nxt  = cur_r;
          steps_nxt = count_ext[COUNT_BITS-1:0];
          if (gds_pkg::func_t'(in_if.func) == gds_pkg::FUNC_LOAD) begin
            cur_nxt = clamp_date;
          end
        end
      end
      gds_pkg::ST_CMP: begin
        diff_nxt = '0;
        if (cur_r < in_r) begin
          work_nxt = cur_r;
          tgt_nxt  = in_r;
          cmp_nxt  = gds_pkg::CMP_LESS;
        end else if (cur_r == in_r) begin
          work_nxt = cur_r;
          tgt_nxt  = in_r;
          cmp_nxt  = gds_pkg::CMP_EQUAL;
        end else begin
          work_nxt = in_r;
          tgt_nxt  = cur_r;
          cmp_nxt  = gds_pkg::CMP_GREATER;
        end
      end
      gds_pkg::ST_STEP: begin
        if (steps_r == '0) begin
          cur_nxt = work_r;
        end else if (at_limit) begin
          cur_nxt   = work_r;
          limit_nxt = 1'b1;
        end else begin
          work_nxt  = step_date;
          steps_nxt = steps_r - 1'b1;
        end
      end
      gds_pkg::ST_DIFF: begin
        if (work_r != tgt_r) begin
          work_nxt = step_date;
          // The count saturates at its all-ones value.
          if (diff_r != '1) begin
            diff_nxt = diff_r + 1'b1;
          end
        end
      end
      gds_pkg::ST_PUSH: begin
        if (push_ok) begin
          out_valid_nxt = 1'b1;
          out_date_nxt  = cur_r;
          out_ok_nxt    = ((func_r == gds_pkg::FUNC_LOAD) ||
                           (func_r == gds_pkg::FUNC_CMP)) ? ok_r : 1'b0;
          out_cmp_nxt   = (func_r == gds_pkg::FUNC_CMP) ? cmp_r : gds_pkg::CMP_LESS;
          out_diff_nxt  = (func_r == gds_pkg::FUNC_CMP) ? diff_r : '0;
          out_limit_nxt = limit_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gds_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      cur_r       <= DATE_LO;
      steps_r     <= '0;
      diff_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
      steps_r     <= steps_nxt;
      diff_r      <= diff_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r      <= work_nxt;
    tgt_r       <= tgt_nxt;
    in_r        <= in_nxt;
    func_r      <= func_nxt;
    ok_r        <= ok_nxt;
    limit_r     <= limit_nxt;
    cmp_r       <= cmp_nxt;
    out_date_r  <= out_date_nxt;
    out_ok_r    <= out_ok_nxt;
    out_cmp_r   <= out_cmp_nxt;
    out_diff_r  <= out_diff_nxt;
    out_limit_r <= out_limit_nxt;
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.out_day        = out_date_r.day;
  assign out_if.out_month      = out_date_r.month;
  assign out_if.out_year       = out_date_r.year;
  assign out_if.input_valid    = out_ok_r;
  assign out_if.compare_result = out_cmp_r;
  assign out_if.day_difference = out_diff_r;
  assign out_if.limit_hit      = out_limit_r;

endmodule
